// ----- rtl/psdc_pkg.sv -----
// Package of shared constants, types and a helper function for the distinct address counter.
`default_nettype none

package psdc_pkg;

    localparam int ADDR_W          = 48;
    localparam int RSSI_W          = 8;
    localparam int FC_W            = 8;
    localparam int CMD_W           = 2;
    localparam int COUNT_W         = 9;
    localparam int TABLE_DEPTH_DEF = 256;

    localparam logic [CMD_W-1:0]  CMD_WIFI   = 2'd0;
    localparam logic [CMD_W-1:0]  CMD_BLE    = 2'd1;
    localparam logic [CMD_W-1:0]  CMD_REPORT = 2'd2;

    localparam logic signed [RSSI_W-1:0] RSSI_THRESHOLD_RESET = -8'sd100;

    localparam logic [FC_W-1:0] FC_TYPE_MASK    = 8'h0C;
    localparam logic [FC_W-1:0] FC_SUBTYPE_MASK = 8'hF0;
    localparam logic [FC_W-1:0] FC_PROBE_REQ    = 8'h40;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic scan_init;
        logic scan_step;
        logic finish_plain;
        logic finish_new;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_report;
        logic keep;
        logic hit;
        logic scan_end;
        logic out_free;
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // Reverses the six bytes of an address.
    function automatic logic [ADDR_W-1:0] reverse_bytes(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] r;
        r = '0;
        for (int i = 0; i < ADDR_W / 8; i++) begin
            r[8*i +: 8] = a[ADDR_W-8-8*i +: 8];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/psdc_if.sv -----
// Handshake interfaces for the observation, result and threshold channels.
`default_nettype none

interface psdc_in_if
    import psdc_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic                     is_management;
    logic signed [RSSI_W-1:0] rssi;
    logic [FC_W-1:0]          fc_byte;
    logic [ADDR_W-1:0]        address;

    modport source (output valid, command, is_management, rssi, fc_byte, address,
                    input ready);
    modport sink (input valid, command, is_management, rssi, fc_byte, address,
                  output ready);
endinterface

interface psdc_out_if
    import psdc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               newly_added;
    logic               dropped_full;
    logic [COUNT_W-1:0] distinct_count;

    modport source (output valid, newly_added, dropped_full, distinct_count, input ready);
    modport sink (input valid, newly_added, dropped_full, distinct_count, output ready);
endinterface

interface psdc_cfg_if
    import psdc_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [RSSI_W-1:0] min_rssi;

    modport source (output valid, min_rssi, input ready);
    modport sink (input valid, min_rssi, output ready);
endinterface

`default_nettype wire

// ----- rtl/psdc_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module psdc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_we,
    input  wire logic [AW-1:0]           i_waddr,
    input  wire logic [WIDTH-1:0]        i_wdata,
    input  wire logic                    i_re,
    input  wire logic [AW-1:0]           i_raddr,
    output logic      [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

`default_nettype wire

// ----- rtl/psdc_ctrl.sv -----
// Controller state machine that sequences capture, table scan, update and result hand-off.
`default_nettype none

module psdc_ctrl
    import psdc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);
    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_status.is_report || !i_status.keep) begin
                    o_cmd.finish_plain = 1'b1;
                    n_state            = S_DONE;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.hit) begin
                    o_cmd.finish_plain = 1'b1;
                    n_state            = S_DONE;
                end else if (i_status.scan_end) begin
                    o_cmd.finish_new = 1'b1;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

`default_nettype wire

// ----- rtl/psdc_dp.sv -----
// Datapath: filter, address key, fill count, scan pointer, address table and result register.
`default_nettype none

module psdc_dp
    import psdc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cmd                     i_cmd,
    output t_status                       o_status,
    input  wire logic [CMD_W-1:0]         i_command,
    input  wire logic                     i_is_management,
    input  wire logic signed [RSSI_W-1:0] i_rssi,
    input  wire logic [FC_W-1:0]          i_fc_byte,
    input  wire logic [ADDR_W-1:0]        i_address,
    input  wire logic                     i_cfg_we,
    input  wire logic signed [RSSI_W-1:0] i_cfg_threshold,
    input  wire logic                     i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_newly_added,
    output logic                          o_dropped_full,
    output logic [COUNT_W-1:0]            o_distinct_count
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    function automatic logic [COUNT_W-1:0] to_count(input logic [CW-1:0] v);
        logic [CW+COUNT_W-1:0] w;
        w = {{COUNT_W{1'b0}}, v};
        return w[COUNT_W-1:0];
    endfunction

    logic signed [RSSI_W-1:0] r_thr;
    logic                     r_is_report;
    logic                     r_keep;
    logic [ADDR_W-1:0]        r_key;
    logic [CW-1:0]            r_fill;
    logic [CW-1:0]            r_idx;
    logic                     r_pend;
    logic                     r_res_added;
    logic                     r_res_dropped;
    logic [COUNT_W-1:0]       r_res_count;
    logic                     r_out_valid;
    logic                     r_out_added;
    logic                     r_out_dropped;
    logic [COUNT_W-1:0]       r_out_count;

    logic              n_keep;
    logic [ADDR_W-1:0] n_key;
    logic              rssi_ok;
    logic              probe_req;
    logic              issue;
    logic              full;
    logic [CW-1:0]     fill_inc;
    logic [ADDR_W-1:0] rdata;

    assign rssi_ok   = (i_rssi >= r_thr);
    assign probe_req = ((i_fc_byte & (FC_TYPE_MASK | FC_SUBTYPE_MASK)) == FC_PROBE_REQ);

    always_comb begin
        n_keep = 1'b0;
        n_key  = i_address;
        case (i_command)
            CMD_WIFI: n_keep = i_is_management && rssi_ok && probe_req;
            CMD_BLE: begin
                n_keep = rssi_ok;
                n_key  = reverse_bytes(i_address);
            end
            default: n_keep = 1'b0;
        endcase
    end

    assign issue    = (r_idx < r_fill);
    assign full     = (r_fill == CW'(TABLE_DEPTH));
    assign fill_inc = r_fill + CW'(1);

    psdc_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.finish_new && !full),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (r_key),
        .i_re    (i_cmd.scan_step && issue),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rdata)
    );

    assign o_status.is_report = r_is_report;
    assign o_status.keep      = r_keep;
    assign o_status.hit       = r_pend && (rdata == r_key);
    assign o_status.scan_end  = !issue && !r_pend;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= RSSI_THRESHOLD_RESET;
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_threshold;
            end
            if (i_cmd.scan_init) begin
                r_pend <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_pend <= issue;
            end
            if (i_cmd.finish_plain && r_is_report) begin
                r_fill <= '0;
            end else if (i_cmd.finish_new && !full) begin
                r_fill <= fill_inc;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_is_report <= (i_command == CMD_REPORT);
            r_keep      <= n_keep;
            r_key       <= n_key;
        end
        if (i_cmd.scan_init) begin
            r_idx <= '0;
        end else if (i_cmd.scan_step && issue) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.finish_plain) begin
            r_res_added   <= 1'b0;
            r_res_dropped <= 1'b0;
            r_res_count   <= to_count(r_fill);
        end else if (i_cmd.finish_new) begin
            r_res_added   <= !full;
            r_res_dropped <= full;
            r_res_count   <= full ? to_count(r_fill) : to_count(fill_inc);
        end
        if (i_cmd.load_out) begin
            r_out_added   <= r_res_added;
            r_out_dropped <= r_res_dropped;
            r_out_count   <= r_res_count;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_newly_added    = r_out_added;
    assign o_dropped_full   = r_out_dropped;
    assign o_distinct_count = r_out_count;
endmodule

`default_nettype wire

// ----- rtl/probe_source_distinct_counter_top.sv -----
// Top level of the distinct device address counter.
// Use: each transaction on i_in carries one observation or command. A WiFi
// observation counts when it is a management frame, a probe request by its
// frame-control byte and at least as strong as the threshold; a BLE discovery
// counts when it is strong enough, with its address bytes reversed. A report
// command returns the count and empties the table. Every input transaction
// yields exactly one result transaction on o_out.
// The threshold is written by a transaction on i_cfg, which is always ready;
// write it only while no observation is in flight.
// An item is captured and then checked: a report or a filtered-out item goes
// straight to its result, while a kept item is looked up by scanning the
// filled part of the table RAM one entry per cycle through its single read
// port, comparing each entry on the registered read data; a miss is added
// unless the table is full. The block works on one item at a time.
// The result register frees the controller: the next item is accepted while a
// result still waits, but it stalls in its last step until the register empties.
// Reset clears the fill count, the threshold (back to -100 dBm) and the
// output valid; the table contents need no clearing, as only filled entries are read.
`default_nettype none

module probe_source_distinct_counter_top
    import psdc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    psdc_in_if.sink     i_in,
    psdc_out_if.source  o_out,
    psdc_cfg_if.sink    i_cfg
);
    t_cmd    cmd;
    t_status status;

    // Threshold writes are taken at any time.
    assign i_cfg.ready = 1'b1;

    psdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    psdc_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_command        (i_in.command),
        .i_is_management  (i_in.is_management),
        .i_rssi           (i_in.rssi),
        .i_fc_byte        (i_in.fc_byte),
        .i_address        (i_in.address),
        .i_cfg_we         (i_cfg.valid),
        .i_cfg_threshold  (i_cfg.min_rssi),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_newly_added    (o_out.newly_added),
        .o_dropped_full   (o_out.dropped_full),
        .o_distinct_count (o_out.distinct_count)
    );
endmodule

`default_nettype wire

// ----- rtl/psdc_checker.sv -----
// Port-level checker for the distinct address counter and its bind to the top level.
`default_nettype none

module psdc_checker
    import psdc_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               i_in_ready,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic               i_newly_added,
    input wire logic               i_dropped_full,
    input wire logic [COUNT_W-1:0] i_distinct_count
);
    // Nothing is offered on the result side straight after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_newly_added)
            && $stable(i_dropped_full) && $stable(i_distinct_count))
        else $error("stalled result changed");

    // An address is either added or dropped, never both.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_newly_added && i_dropped_full))
        else $error("added and dropped together");

    // An added address leaves at least one entry in the table.
    a_added_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_newly_added |-> i_distinct_count != '0)
        else $error("address added but count is zero");

    // One item at a time: no second input straight after an accepted one.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after an accepted transaction");
endmodule

bind probe_source_distinct_counter_top psdc_checker u_psdc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_newly_added    (o_out.newly_added),
    .i_dropped_full   (o_out.dropped_full),
    .i_distinct_count (o_out.distinct_count)
);

`default_nettype wire

// ----- dv/psdc_count_checker.sv -----
// Checker that watches the counter's channels, predicts every result and compares it.
module psdc_count_checker
    import psdc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    psdc_in_if        i_in,
    psdc_out_if       i_out,
    psdc_cfg_if       i_cfg,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_results,
    output int        o_added,
    output int        o_dropped,
    output int        o_reports,
    output int        o_peak_fill
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               added;
        logic               dropped;
        logic [COUNT_W-1:0] count;
    } t_count_result;

    t_count_result            expected_counts[$];
    logic [ADDR_W-1:0]        heard_addrs[$];
    logic signed [RSSI_W-1:0] threshold_now = RSSI_THRESHOLD_RESET;
    int fails = 0, results = 0, added = 0, dropped = 0, reports = 0, peak_fill = 0;

    // Works out the result of one transaction and updates the address table.
    function automatic t_count_result predict_count(
        input logic [CMD_W-1:0]         cmd,
        input logic                     mgmt,
        input logic signed [RSSI_W-1:0] rssi,
        input logic [FC_W-1:0]          fc,
        input logic [ADDR_W-1:0]        addr
    );
        t_count_result     r;
        logic              keep;
        logic              hit;
        logic [ADDR_W-1:0] key;
        r    = '0;
        keep = 1'b0;
        hit  = 1'b0;
        key  = addr;
        if (cmd == CMD_WIFI) begin
            keep = mgmt && (rssi >= threshold_now) && ((fc & FC_TYPE_MASK) == '0) &&
                   ((fc & FC_SUBTYPE_MASK) == FC_PROBE_REQ);
        end else if (cmd == CMD_BLE) begin
            keep = (rssi >= threshold_now);
            for (int b = 0; b < ADDR_W / 8; b++) begin
                key[8*b +: 8] = addr[ADDR_W-8-8*b +: 8];
            end
        end else if (cmd == CMD_REPORT) begin
            r.count = COUNT_W'(heard_addrs.size());
            heard_addrs.delete();
            return r;
        end
        if (keep) begin
            foreach (heard_addrs[i]) begin
                if (heard_addrs[i] == key) begin
                    hit = 1'b1;
                end
            end
            if (!hit) begin
                if (heard_addrs.size() < TABLE_DEPTH) begin
                    heard_addrs.push_back(key);
                    r.added = 1'b1;
                end else begin
                    r.dropped = 1'b1;
                end
            end
        end
        r.count = COUNT_W'(heard_addrs.size());
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_count_result got;
        t_count_result want;
        if (!i_rst_n) begin
            threshold_now = RSSI_THRESHOLD_RESET;
            heard_addrs.delete();
            expected_counts.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                threshold_now = i_cfg.min_rssi;
            end
            if (i_out.valid && i_out.ready) begin
                got.added   = i_out.newly_added;
                got.dropped = i_out.dropped_full;
                got.count   = i_out.distinct_count;
                results++;
                if (expected_counts.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("Unexpected result %0d: added=%0b dropped=%0b count=%0d",
                                 results, got.added, got.dropped, got.count);
                    end
                end else begin
                    want = expected_counts.pop_front();
                    if ((got.added !== want.added) || (got.dropped !== want.dropped) ||
                        (got.count !== want.count)) begin
                        fails++;
                        if (fails <= 10) begin
                            $display({"Mismatch on result %0d: expected added=%0b dropped=%0b ",
                                      "count=%0d, got added=%0b dropped=%0b count=%0d"},
                                     results, want.added, want.dropped, want.count,
                                     got.added, got.dropped, got.count);
                        end
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                want = predict_count(i_in.command, i_in.is_management, i_in.rssi,
                                     i_in.fc_byte, i_in.address);
                expected_counts.push_back(want);
                if (want.added) added++;
                if (want.dropped) dropped++;
                if (i_in.command == CMD_REPORT) reports++;
                if (heard_addrs.size() > peak_fill) peak_fill = heard_addrs.size();
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_counts.size();
        o_results    <= results;
        o_added      <= added;
        o_dropped    <= dropped;
        o_reports    <= reports;
        o_peak_fill  <= peak_fill;
    end

endmodule

// ----- dv/probe_source_distinct_counter_top_tb.sv -----
// Testbench top for the distinct address counter: clock, reset, stimulus and verdict.
module probe_source_distinct_counter_top_tb
    import psdc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // The one command code that the block leaves unused.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // The random part runs in windows, each closed by a report. The window
    // numbered BIG_WINDOW is the long one that fills the table and then overflows it.
    localparam int N_WINDOWS   = 7;
    localparam int BIG_WINDOW  = 4;
    localparam int HOLD_WINDOW = 0;
    localparam int BIG_ITEMS   = 340;

    // The long receiver hold-off, well above the worst per-item latency so
    // that the result register and the controller both fill and the input stalls.
    localparam int HOLD_CYCLES = 1500;

    // Slowest correct run is at most 570 items, each scanning a full table, plus both
    // sides idling at their worst; this limit is several times that.
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
    } t_sent_addr;

    logic i_clk = 1'b0;
    logic i_rst_n;

    psdc_in_if  in_ch();
    psdc_out_if out_ch();
    psdc_cfg_if cfg_ch();

    int fail_count, pending, results, added, dropped, reports, peak_fill;

    // Flags quiet and hold_req are shared with the result sink; the rest is stimulus state.
    bit         quiet    = 1'b0;
    bit         hold_req = 1'b0;
    int         gap_pct  = 20;
    int         cur_threshold = RSSI_THRESHOLD_RESET;
    t_sent_addr sent_addrs[$];

    int unsigned cycle_count = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    probe_source_distinct_counter_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    psdc_count_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results),
        .o_added      (added),
        .o_dropped    (dropped),
        .o_reports    (reports),
        .o_peak_fill  (peak_fill)
    );

    // Offers one transaction, after an optional idle burst, and returns at the
    // edge where it is accepted. Valid is left high so that a following item
    // can go out back to back without the line dropping in between.
    task automatic send_item(
        input logic [CMD_W-1:0]         cmd,
        input logic                     mgmt,
        input logic signed [RSSI_W-1:0] rssi,
        input logic [FC_W-1:0]          fc,
        input logic [ADDR_W-1:0]        addr
    );
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.command       <= cmd;
        in_ch.is_management <= mgmt;
        in_ch.rssi          <= rssi;
        in_ch.fc_byte       <= fc;
        in_ch.address       <= addr;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Builds one random transaction. Most are observations that pass the
    // filters, so that the table lookup is exercised; the address is either a
    // fresh one or a repeat of one already sent. The rest are broken in one way
    // (not management, wrong type, wrong subtype, too weak) or are pure noise.
    task automatic send_random_item(input int wellformed_pct, input int fresh_pct,
                                    input bit allow_report);
        t_sent_addr               pick;
        logic [CMD_W-1:0]         cmd;
        logic                     mgmt;
        logic signed [RSSI_W-1:0] rssi;
        logic [FC_W-1:0]          fc;
        logic [ADDR_W-1:0]        addr;
        cmd  = $urandom_range(0, 1) ? CMD_BLE : CMD_WIFI;
        mgmt = 1'b1;
        rssi = RSSI_W'(cur_threshold + int'($urandom_range(0, 127 - cur_threshold)));
        fc   = FC_PROBE_REQ | FC_W'($urandom_range(0, 3));
        addr = ADDR_W'({$urandom, $urandom});
        if (sent_addrs.size() > 0 && $urandom_range(0, 99) >= fresh_pct) begin
            pick = sent_addrs[$urandom_range(0, sent_addrs.size() - 1)];
            cmd  = pick.cmd;
            addr = pick.addr;
        end else begin
            sent_addrs.push_back({cmd, addr});
            if (sent_addrs.size() > 64) begin
                void'(sent_addrs.pop_front());
            end
        end
        // For a BLE discovery the WiFi-only fields carry anything at all.
        if (cmd == CMD_BLE) begin
            mgmt = 1'($urandom_range(0, 1));
            fc   = FC_W'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 99) >= wellformed_pct) begin
            case ($urandom_range(0, 5))
                0: mgmt = 1'b0;
                1: fc[3:2] = 2'($urandom_range(1, 3));
                2: fc[7:4] = 4'($urandom_range(5, 19));
                3: begin
                    if (cur_threshold > -128) begin
                        rssi = RSSI_W'(cur_threshold -
                                       int'($urandom_range(1, cur_threshold + 128)));
                    end
                end
                default: begin
                    cmd = CMD_W'($urandom_range(0, 3));
                    if (cmd == CMD_REPORT && !allow_report) begin
                        cmd = CMD_UNUSED;
                    end
                    mgmt = 1'($urandom_range(0, 1));
                    rssi = RSSI_W'($urandom_range(0, 255));
                    fc   = FC_W'($urandom_range(0, 255));
                end
            endcase
        end
        send_item(cmd, mgmt, rssi, fc, addr);
    endtask

    // Waits until every result that the checker expects has come back.
    task automatic wait_drained();
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin : stimulus
        int thr;
        int win_len;
        in_ch.valid           <= 1'b0;
        in_ch.command         <= CMD_WIFI;
        in_ch.is_management   <= 1'b0;
        in_ch.rssi            <= '0;
        in_ch.fc_byte         <= '0;
        in_ch.address         <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.min_rssi       <= RSSI_THRESHOLD_RESET;
        i_rst_n               <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, run on the threshold left by reset (-100 dBm).
        // A report on an empty table, then a first probe request and its repeat.
        send_item(CMD_REPORT, 1'b0, 8'sd0, 8'h00, 48'h0);
        send_item(CMD_WIFI, 1'b1, 8'sd127, 8'h40, 48'h0);
        send_item(CMD_WIFI, 1'b1, 8'sd127, 8'h40, 48'h0);
        // Probe request with the low control bits set, exactly at the threshold.
        send_item(CMD_WIFI, 1'b1, -8'sd100, 8'h43, 48'hFFFF_FFFF_FFFF);
        // One below the threshold, the weakest possible, not management.
        send_item(CMD_WIFI, 1'b1, -8'sd101, 8'h40, 48'h1234_5678_9ABC);
        send_item(CMD_WIFI, 1'b1, -8'sd128, 8'h40, 48'h1234_5678_9ABC);
        send_item(CMD_WIFI, 1'b0, 8'sd127, 8'h40, 48'h1234_5678_9ABC);
        // Frame types other than management, and subtypes other than probe request.
        send_item(CMD_WIFI, 1'b1, 8'sd127, 8'h44, 48'h1234_5678_9ABC);
        send_item(CMD_WIFI, 1'b1, 8'sd127, 8'h48, 48'h1234_5678_9ABC);
        send_item(CMD_WIFI, 1'b1, 8'sd127, 8'h4C, 48'h1234_5678_9ABC);
        send_item(CMD_WIFI, 1'b1, 8'sd127, 8'h50, 48'h1234_5678_9ABC);
        send_item(CMD_WIFI, 1'b1, 8'sd127, 8'hF0, 48'h1234_5678_9ABC);
        // A BLE address is stored byte-reversed, so the WiFi form that follows
        // is the same device and must be found rather than added.
        send_item(CMD_BLE, 1'b0, 8'sd127, 8'h00, 48'h0102_0304_0506);
        send_item(CMD_WIFI, 1'b1, 8'sd127, 8'h40, 48'h0605_0403_0201);
        // BLE ignores the management bit and the frame-control byte.
        send_item(CMD_BLE, 1'b0, -8'sd100, 8'hFF, 48'hA55A_C33C_0FF0);
        send_item(CMD_BLE, 1'b1, -8'sd128, 8'h40, 48'h5AA5_3CC3_F00F);
        // The unused command changes nothing; then two reports in a row.
        send_item(CMD_UNUSED, 1'b1, 8'sd127, 8'h40, 48'h0BAD_F00D_0001);
        send_item(CMD_REPORT, 1'b1, 8'sd127, 8'h40, 48'h0BAD_F00D_0001);
        send_item(CMD_REPORT, 1'b0, -8'sd1, 8'hFF, 48'hFFFF_FFFF_FFFF);
        in_ch.valid <= 1'b0;

        // Random part. The threshold is rewritten only while the block is idle.
        for (int w = 0; w < N_WINDOWS; w++) begin
            wait_drained();
            case (w)
                0:          thr = -128;
                1:          thr = 127;
                2:          thr = 0;
                BIG_WINDOW: thr = -128;
                6:          thr = RSSI_THRESHOLD_RESET;
                default:    thr = int'($urandom_range(0, 255)) - 128;
            endcase
            cfg_ch.valid    <= 1'b1;
            cfg_ch.min_rssi <= RSSI_W'(thr);
            do @(posedge i_clk); while (!cfg_ch.ready);
            cfg_ch.valid <= 1'b0;
            cur_threshold = thr;

            // The last window runs with no idling on either side.
            quiet   = (w == N_WINDOWS - 1);
            gap_pct = quiet ? 0 : $urandom_range(0, 40);
            if (w == HOLD_WINDOW) begin
                hold_req = 1'b1;
            end
            if (w == BIG_WINDOW) begin
                win_len = BIG_ITEMS;
            end else begin
                win_len = $urandom_range(18, 34);
            end
            for (int i = 0; i < win_len; i++) begin
                if (w == BIG_WINDOW) begin
                    send_random_item(90, 95, 1'b0);
                end else begin
                    send_random_item(70, 55, 1'b1);
                end
            end
            send_item(CMD_REPORT, 1'($urandom_range(0, 1)), RSSI_W'($urandom_range(0, 255)),
                      FC_W'($urandom_range(0, 255)), ADDR_W'({$urandom, $urandom}));
            in_ch.valid <= 1'b0;
        end

        wait_drained();
        repeat (TABLE_DEPTH_DEF + 8) @(posedge i_clk);
        $display("Checked %0d results: %0d addresses added, %0d dropped on a full table, %0d %s",
                 results, added, dropped, reports, "reports.");
        $display("Table fill peaked at %0d of %0d; threshold taken through %s",
                 peak_fill, TABLE_DEPTH_DEF, "-128, -100, 0, 127 and random values.");
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // The result side: random stall bursts between runs of readiness, one long
    // hold-off on request, and steady readiness once the run turns quiet.
    initial begin : result_sink
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left   = 0;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (quiet) begin
                out_ch.ready <= 1'b1;
            end else begin
                if (stall_left == 0 && run_left == 0) begin
                    stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 13);
                    run_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 30);
                end
                if (stall_left > 0) begin
                    out_ch.ready <= 1'b0;
                    stall_left--;
                end else begin
                    out_ch.ready <= 1'b1;
                    run_left--;
                end
            end
        end
    end

    // Watchdog: a run that never drains ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule
